>>> rtl/nsc_pkg.sv
package nsc_pkg;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_G       = 8'h47;
  localparam logic [7:0] CH_P       = 8'h50;
  localparam logic [7:0] CH_N       = 8'h4E;

  localparam int unsigned NUM_KINDS = 6;

  typedef enum logic [2:0] {
    ST_BAD_PREFIX  = 3'd0,
    ST_NO_STAR     = 3'd1,
    ST_BAD_SUM     = 3'd2,
    ST_UNKNOWN     = 3'd3,
    ST_FEW_FIELDS  = 3'd4,
    ST_ACCEPTED    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    KIND_TXT  = 3'd0,
    KIND_RMC  = 3'd1,
    KIND_GGA  = 3'd2,
    KIND_GLL  = 3'd3,
    KIND_VTG  = 3'd4,
    KIND_ZDA  = 3'd5,
    KIND_NONE = 3'd6
  } kind_t;

  // field text: first char in chars[0], length saturates at 7
  typedef struct packed {
    logic [2:0]      len;
    logic [2:0][7:0] chars;
  } field_text_t;

  // line state as seen by the classifier when a newline arrives
  typedef struct packed {
    logic        prefix_ok;
    logic        star_seen;
    logic [7:0]  xor_at_star;
    logic [7:0]  hex_acc;
    logic        hex_ovf;
    logic [4:0]  commas_at_star;
    field_text_t f0_at_star;
    field_text_t f3_at_star;
  } line_sum_t;

  typedef struct packed {
    status_t    status;
    kind_t      kind;
    logic [4:0] field_count;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
  } result_t;

  // names packed with the first char in the low byte
  function automatic logic [23:0] kind_name(input logic [2:0] idx);
    logic [23:0] n;
    unique case (idx)
      KIND_TXT: n = "TXT";
      KIND_RMC: n = "CMR";
      KIND_GGA: n = "AGG";
      KIND_GLL: n = "LLG";
      KIND_VTG: n = "GTV";
      KIND_ZDA: n = "ADZ";
      default:  n = '0;
    endcase
    return n;
  endfunction

  function automatic logic [5:0] kind_min_fields(input logic [2:0] idx);
    logic [5:0] m;
    unique case (idx)
      KIND_TXT: m = 6'd5;
      KIND_RMC: m = 6'd11;
      KIND_GGA: m = 6'd14;
      KIND_GLL: m = 6'd7;
      KIND_VTG: m = 6'd9;
      KIND_ZDA: m = 6'd5;
      default:  m = '0;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/nsc_in_if.sv
interface nsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/nsc_out_if.sv
interface nsc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [2:0] sentence_kind;
  logic [4:0] field_count;
  logic [7:0] computed_sum;
  logic [7:0] received_sum;

  modport source (output valid, output status, output sentence_kind, output field_count,
                  output computed_sum, output received_sum, input ready);
  modport sink   (input valid, input status, input sentence_kind, input field_count,
                  input computed_sum, input received_sum, output ready);
endinterface

>>> rtl/nmea_sentence_checker_unit.sv
// NMEA sentence checker.
// in_ch carries one received byte per word; a newline byte ends the line.
// out_ch carries one status word per line: status, sentence_kind,
// field_count, computed_sum and received_sum.
// Throughput: one byte per cycle, sustained, as long as out_ch drains.
// A newline passes the input register, then the result register, before its
// status word shows on out_ch. Bytes other than newline produce no word.
// The line state is a handful of small registers updated by one byte per
// cycle as long as out_ch drains; the status is decoded from them when the
// newline leaves the input register.
// Reset (rst_n low, synchronous) clears the line state and empties both
// registers. If out_ch stalls while a status word is held, ordinary bytes
// still flow; a following newline waits in the input register, and in_ch
// ready drops until the held word is taken.
module nmea_sentence_checker_unit
  import nsc_pkg::*;
#(
  parameter int unsigned MAX_FIELDS = 20
) (
  input  logic      clk,
  input  logic      rst_n,
  nsc_in_if.sink    in_ch,
  nsc_out_if.source out_ch
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_res_r;

  logic       out_free;
  logic       s1_is_nl;
  logic       s1_go;
  logic       in_take;
  line_sum_t  line_sum;
  result_t    result;

  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_is_nl = (s1_byte_r == CH_NEWLINE);
  assign s1_go    = s1_valid_r && (!s1_is_nl || out_free);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_take  = in_ch.valid && in_ch.ready;

  nsc_scanner #(
    .MAX_FIELDS (MAX_FIELDS)
  ) u_scanner (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (s1_go),
    .byte_in  (s1_byte_r),
    .line_sum (line_sum)
  );

  nsc_classifier u_classifier (
    .line_sum (line_sum),
    .result   (result)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) s1_valid_nxt = 1'b1;
    else if (s1_go) s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (s1_go && s1_is_nl) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_byte_r <= in_ch.rx_byte;
    if (s1_go && s1_is_nl) out_res_r <= result;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_res_r.status;
  assign out_ch.sentence_kind = out_res_r.kind;
  assign out_ch.field_count   = out_res_r.field_count;
  assign out_ch.computed_sum  = out_res_r.computed_sum;
  assign out_ch.received_sum  = out_res_r.received_sum;

endmodule

>>> rtl/nsc_scanner.sv
module nsc_scanner
  import nsc_pkg::*;
#(
  parameter int unsigned MAX_FIELDS = 20
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  logic [7:0] byte_in,
  output line_sum_t line_sum
);

  localparam logic [4:0] COMMA_SAT = 5'(MAX_FIELDS - 1);

  logic [1:0]  pos_r, pos_nxt;
  logic        prefix_good_r, prefix_good_nxt;
  logic [7:0]  run_xor_r, run_xor_nxt;
  logic [7:0]  xor_star_r, xor_star_nxt;
  logic        star_seen_r, star_seen_nxt;
  logic [7:0]  hex_acc_r, hex_acc_nxt;
  logic        hex_ovf_r, hex_ovf_nxt;
  logic        hex_stop_r, hex_stop_nxt;
  logic [4:0]  commas_r, commas_nxt;
  logic [4:0]  commas_star_r, commas_star_nxt;
  field_text_t f0_r, f0_nxt;
  field_text_t f3_r, f3_nxt;
  field_text_t f0_star_r, f0_star_nxt;
  field_text_t f3_star_r, f3_star_nxt;

  logic        digit_ok;
  logic [3:0]  digit;

  function automatic field_text_t text_append(input field_text_t t, input logic [7:0] b);
    field_text_t r;
    r = t;
    if (t.len < 3'd3) r.chars[t.len[1:0]] = b;
    if (t.len != 3'd7) r.len = t.len + 3'd1;
    return r;
  endfunction

  always_comb begin
    digit_ok = 1'b1;
    digit    = 4'd0;
    if (byte_in >= "0" && byte_in <= "9") begin
      digit = 4'(byte_in - "0");
    end else if (byte_in >= "a" && byte_in <= "f") begin
      digit = 4'(byte_in - "a" + 8'd10);
    end else if (byte_in >= "A" && byte_in <= "F") begin
      digit = 4'(byte_in - "A" + 8'd10);
    end else begin
      digit_ok = 1'b0;
    end
  end

  always_comb begin
    pos_nxt         = pos_r;
    prefix_good_nxt = prefix_good_r;
    run_xor_nxt     = run_xor_r;
    xor_star_nxt    = xor_star_r;
    star_seen_nxt   = star_seen_r;
    hex_acc_nxt     = hex_acc_r;
    hex_ovf_nxt     = hex_ovf_r;
    hex_stop_nxt    = hex_stop_r;
    commas_nxt      = commas_r;
    commas_star_nxt = commas_star_r;
    f0_nxt          = f0_r;
    f3_nxt          = f3_r;
    f0_star_nxt     = f0_star_r;
    f3_star_nxt     = f3_star_r;

    if (step) begin
      if (byte_in == CH_NEWLINE) begin
        pos_nxt         = '0;
        prefix_good_nxt = 1'b1;
        run_xor_nxt     = '0;
        xor_star_nxt    = '0;
        star_seen_nxt   = 1'b0;
        hex_acc_nxt     = '0;
        hex_ovf_nxt     = 1'b0;
        hex_stop_nxt    = 1'b0;
        commas_nxt      = '0;
        commas_star_nxt = '0;
        f0_nxt          = '0;
        f3_nxt          = '0;
        f0_star_nxt     = '0;
        f3_star_nxt     = '0;
      end else begin
        unique case (pos_r)
          2'd0:    prefix_good_nxt = prefix_good_r && (byte_in == CH_DOLLAR);
          2'd1:    prefix_good_nxt = prefix_good_r && (byte_in == CH_G);
          2'd2:    prefix_good_nxt = prefix_good_r && (byte_in == CH_P || byte_in == CH_N);
          default: prefix_good_nxt = prefix_good_r;
        endcase

        if (pos_r != 2'd0) begin
          if (byte_in == CH_STAR) begin
            xor_star_nxt    = run_xor_r;
            star_seen_nxt   = 1'b1;
            hex_acc_nxt     = '0;
            hex_ovf_nxt     = 1'b0;
            hex_stop_nxt    = 1'b0;
            commas_star_nxt = commas_r;
            f0_star_nxt     = f0_r;
            f3_star_nxt     = f3_r;
          end else if (star_seen_r && !hex_stop_r) begin
            if (!digit_ok) begin
              hex_stop_nxt = 1'b1;
            end else begin
              if (hex_acc_r[7:4] != 4'd0) hex_ovf_nxt = 1'b1;
              hex_acc_nxt = {hex_acc_r[3:0], digit};
            end
          end
          run_xor_nxt = run_xor_r ^ byte_in;
        end

        if (pos_r == 2'd3) begin
          if (byte_in == CH_COMMA) begin
            if (commas_r < COMMA_SAT) commas_nxt = commas_r + 5'd1;
          end else if (commas_r == 5'd0) begin
            f0_nxt = text_append(f0_r, byte_in);
          end else if (commas_r == 5'd3) begin
            f3_nxt = text_append(f3_r, byte_in);
          end
        end

        if (pos_r != 2'd3) pos_nxt = pos_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      prefix_good_r <= 1'b1;
      run_xor_r     <= '0;
      xor_star_r    <= '0;
      star_seen_r   <= 1'b0;
      hex_acc_r     <= '0;
      hex_ovf_r     <= 1'b0;
      hex_stop_r    <= 1'b0;
      commas_r      <= '0;
      commas_star_r <= '0;
      f0_r          <= '0;
      f3_r          <= '0;
      f0_star_r     <= '0;
      f3_star_r     <= '0;
    end else begin
      pos_r         <= pos_nxt;
      prefix_good_r <= prefix_good_nxt;
      run_xor_r     <= run_xor_nxt;
      xor_star_r    <= xor_star_nxt;
      star_seen_r   <= star_seen_nxt;
      hex_acc_r     <= hex_acc_nxt;
      hex_ovf_r     <= hex_ovf_nxt;
      hex_stop_r    <= hex_stop_nxt;
      commas_r      <= commas_nxt;
      commas_star_r <= commas_star_nxt;
      f0_r          <= f0_nxt;
      f3_r          <= f3_nxt;
      f0_star_r     <= f0_star_nxt;
      f3_star_r     <= f3_star_nxt;
    end
  end

  assign line_sum.prefix_ok      = prefix_good_r && (pos_r == 2'd3);
  assign line_sum.star_seen      = star_seen_r;
  assign line_sum.xor_at_star    = xor_star_r;
  assign line_sum.hex_acc        = hex_acc_r;
  assign line_sum.hex_ovf        = hex_ovf_r;
  assign line_sum.commas_at_star = commas_star_r;
  assign line_sum.f0_at_star     = f0_star_r;
  assign line_sum.f3_at_star     = f3_star_r;

endmodule

>>> rtl/nsc_classifier.sv
module nsc_classifier
  import nsc_pkg::*;
(
  input  line_sum_t line_sum,
  output result_t   result
);

  logic [5:0]           count;
  logic [NUM_KINDS-1:0] hit;
  logic [2:0]           sel;
  logic                 any_hit;

  assign count = {1'b0, line_sum.commas_at_star} + 6'd1;

  always_comb begin
    for (int i = 0; i < NUM_KINDS; i++) begin
      hit[i] = (line_sum.f0_at_star.len == 3'd3 &&
                line_sum.f0_at_star.chars == kind_name(3'(i))) ||
               (count >= 6'd4 && line_sum.f3_at_star.len == 3'd3 &&
                line_sum.f3_at_star.chars == kind_name(3'(i)));
    end
  end

  // lowest table index wins
  always_comb begin
    sel = 3'd0;
    for (int i = NUM_KINDS - 1; i >= 0; i--) begin
      if (hit[i]) sel = 3'(i);
    end
  end

  assign any_hit = |hit;

  always_comb begin
    result.status       = ST_BAD_PREFIX;
    result.kind         = KIND_NONE;
    result.field_count  = '0;
    result.computed_sum = '0;
    result.received_sum = '0;
    priority if (!line_sum.prefix_ok) begin
      result.status = ST_BAD_PREFIX;
    end else if (!line_sum.star_seen) begin
      result.status = ST_NO_STAR;
    end else begin
      result.computed_sum = line_sum.xor_at_star;
      result.received_sum = line_sum.hex_acc;
      if (line_sum.hex_ovf || line_sum.xor_at_star[7] ||
          line_sum.xor_at_star != line_sum.hex_acc) begin
        result.status = ST_BAD_SUM;
      end else begin
        result.field_count = count[4:0];
        if (!any_hit) begin
          result.status = ST_UNKNOWN;
        end else begin
          result.kind   = kind_t'(sel);
          result.status = (count >= kind_min_fields(sel)) ? ST_ACCEPTED : ST_FEW_FIELDS;
        end
      end
    end
  end

endmodule
